// ===== hdl/pcs_pkg.sv =====
// Package for the streaming Pearson correlation block: widths, types,
// state and phase codes and status codes. No dependencies.
`default_nettype none
package pcs_pkg;

   localparam int MAX_SAMPLES = 65536;
   localparam int SAMPLE_BITS = 24;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int SUM_S_W     = SAMPLE_BITS + CNT_W;
   localparam int SUM_P_W     = 64;
   localparam int ALU_W       = 98;
   localparam int ROOT_W      = 41;
   localparam int MPL_W       = 42;
   localparam int SQRT_STEPS  = 41;
   localparam int DIV_STEPS   = 96;
   localparam int Q_FRAC      = 15;
   localparam int CORR_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int STEP_W      = 7;
   localparam int SQRT_ALIGN  = ALU_W - 2 * SQRT_STEPS;
   localparam int DIV_ALIGN   = Q_FRAC + ALU_W - DIV_STEPS;
   localparam int CORR_MAX    = 32767;

   typedef logic [CNT_W-1:0]           cnt_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_S_W-1:0]  sum_s_type;
   typedef logic signed [SUM_P_W-1:0]  sum_p_type;
   typedef logic [ALU_W-1:0]           alu_word_type;
   typedef logic [ROOT_W-1:0]          root_type;
   typedef logic [MPL_W-1:0]           mpl_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic [CORR_W-1:0]          corr_type;
   typedef logic [STATUS_W-1:0]        status_type;

   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_FLAT = 2'd1;
   localparam status_type STATUS_OVF  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MXY,
      ST_MXX,
      ST_MYY,
      ST_ACC,
      ST_FIN,
      ST_LOAD,
      ST_MUL,
      ST_CHECK,
      ST_SQRT,
      ST_DIV_LD,
      ST_DIV,
      ST_RES,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_N_XY,
      PH_X_Y,
      PH_N_XX,
      PH_X_X,
      PH_N_YY,
      PH_Y_Y,
      PH_DEN
   } phase_type;

endpackage
`default_nettype wire

// ===== hdl/pearson_correlation_stream.sv =====
// Streaming Pearson correlation: accumulator, sequencer and the shared
// add/subtract unit for the final multiply, square root and divide.
// Depends on pcs_pkg.
//
// Usage:
//   Requests (x, y, last) come in on req_*; one result per set goes out on
//   rsp_* after the request marked last. A request is taken only while the
//   block is idle: req_ready drops after each accumulated pair while one
//   24x24 multiplier forms xy, xx and yy in turn (states MXY, MXX, MYY, ACC);
//   a pair dropped on count overflow keeps req_ready high unless it is last.
//   After the last pair the final stage runs on one shared ~98-bit adder:
//   six shift-add products (one multiplier bit per cycle, stopping when the
//   remaining bits are zero), two 41-step square roots, one more product
//   and a 96-step restoring divide. An overflowed set skips this final
//   stage, and a flat set ends before the square roots.
//   The result sits in an output register; new pairs are taken while it
//   waits. If the receiver still holds the previous result when the next
//   one is done, the sequencer waits in its output state.
//   Reset (synchronous, active high) clears the count, the sums, the
//   overflow flag and the output valid.
`default_nettype none
module pearson_correlation_stream (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire signed [pcs_pkg::SAMPLE_BITS-1:0] req_x_sample,
   input  wire signed [pcs_pkg::SAMPLE_BITS-1:0] req_y_sample,
   input  wire                                  req_last_pair,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [pcs_pkg::CORR_W-1:0]    rsp_correlation,
   output logic [pcs_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pcs_pkg::CNT_W-1:0]            rsp_pair_count
);

   pcs_pkg::state_type   state_ff, state_in;
   pcs_pkg::phase_type   phase_ff, phase_in;

   logic signed [pcs_pkg::SAMPLE_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic                                   last_ff, last_in;
   pcs_pkg::cnt_type     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   pcs_pkg::prod_type    prod_ff, prod_in;
   pcs_pkg::sum_s_type   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   pcs_pkg::sum_p_type   sum_xy_ff, sum_xy_in, sum_xx_ff, sum_xx_in, sum_yy_ff, sum_yy_in;

   pcs_pkg::alu_word_type acc_ff, acc_in, mcand_ff, mcand_in, src_ff, src_in;
   pcs_pkg::alu_word_type rem_ff, rem_in, num_ff, num_in, dx_ff, dx_in;
   pcs_pkg::alu_word_type dy_ff, dy_in, den_ff, den_in;
   pcs_pkg::mpl_type     mplier_ff, mplier_in;
   logic                 sub_ff, sub_in;
   pcs_pkg::root_type    root_ff, root_in, root_x_ff, root_x_in;
   logic                 sq_sel_ff, sq_sel_in;
   pcs_pkg::step_type    step_ff, step_in;
   pcs_pkg::corr_type    q_ff, q_in;
   logic                 sat_ff, sat_in, neg_ff, neg_in;
   pcs_pkg::corr_type    res_corr_ff, res_corr_in;
   pcs_pkg::status_type  res_status_ff, res_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   pcs_pkg::corr_type    rsp_corr_ff, rsp_corr_in;
   pcs_pkg::status_type  rsp_status_ff, rsp_status_in;
   pcs_pkg::cnt_type     rsp_count_ff, rsp_count_in;

   // shared adder
   pcs_pkg::alu_word_type alu_a, alu_b, alu_sum;
   logic                  alu_sub;
   pcs_pkg::alu_word_type bsrc, rem_shift;
   logic signed [pcs_pkg::SAMPLE_BITS-1:0] mul_a, mul_b;
   pcs_pkg::corr_type     mag;
   logic                  dx_bad, dy_bad;

   assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + pcs_pkg::alu_word_type'(alu_sub);

   assign req_ready       = (state_ff == pcs_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = rsp_corr_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pair_count  = rsp_count_ff;

   assign dx_bad = dx_ff[pcs_pkg::ALU_W-1] || (dx_ff == '0);
   assign dy_bad = dy_ff[pcs_pkg::ALU_W-1] || (dy_ff == '0);
   assign mag    = (sat_ff || q_ff[pcs_pkg::CORR_W-1]) ?
                   pcs_pkg::corr_type'(pcs_pkg::CORR_MAX) : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcs_pkg::ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_xx_ff    <= '0;
         sum_yy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_xy_ff    <= sum_xy_in;
         sum_xx_ff    <= sum_xx_in;
         sum_yy_ff    <= sum_yy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      src_ff        <= src_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      den_ff        <= den_in;
      mplier_ff     <= mplier_in;
      sub_ff        <= sub_in;
      root_ff       <= root_in;
      root_x_ff     <= root_x_in;
      sq_sel_ff     <= sq_sel_in;
      step_ff       <= step_in;
      q_ff          <= q_in;
      sat_ff        <= sat_in;
      neg_ff        <= neg_in;
      res_corr_ff   <= res_corr_in;
      res_status_ff <= res_status_in;
      rsp_corr_ff   <= rsp_corr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      prod_in       = prod_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      sum_xy_in     = sum_xy_ff;
      sum_xx_in     = sum_xx_ff;
      sum_yy_in     = sum_yy_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      src_in        = src_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      den_in        = den_ff;
      mplier_in     = mplier_ff;
      sub_in        = sub_ff;
      root_in       = root_ff;
      root_x_in     = root_x_ff;
      sq_sel_in     = sq_sel_ff;
      step_in       = step_ff;
      q_in          = q_ff;
      sat_in        = sat_ff;
      neg_in        = neg_ff;
      res_corr_in   = res_corr_ff;
      res_status_in = res_status_ff;
      rsp_corr_in   = rsp_corr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;
      bsrc          = '0;
      rem_shift     = '0;
      mul_a         = x_ff;
      mul_b         = y_ff;

      case (state_ff)
         pcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_x_sample;
               y_in    = req_y_sample;
               last_in = req_last_pair;
               if (count_ff == pcs_pkg::cnt_type'(pcs_pkg::MAX_SAMPLES)) begin
                  // drop the pair, remember the overflow
                  ovf_in   = 1'b1;
                  state_in = req_last_pair ? pcs_pkg::ST_FIN : pcs_pkg::ST_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = pcs_pkg::ST_MXY;
               end
            end
         end
         pcs_pkg::ST_MXY: begin
            prod_in  = mul_a * mul_b;
            state_in = pcs_pkg::ST_MXX;
         end
         pcs_pkg::ST_MXX: begin
            sum_xy_in = sum_xy_ff + pcs_pkg::sum_p_type'(prod_ff);
            sum_x_in  = sum_x_ff + pcs_pkg::sum_s_type'(x_ff);
            sum_y_in  = sum_y_ff + pcs_pkg::sum_s_type'(y_ff);
            mul_b     = x_ff;
            prod_in   = mul_a * mul_b;
            state_in  = pcs_pkg::ST_MYY;
         end
         pcs_pkg::ST_MYY: begin
            sum_xx_in = sum_xx_ff + pcs_pkg::sum_p_type'(prod_ff);
            mul_a     = y_ff;
            prod_in   = mul_a * mul_b;
            state_in  = pcs_pkg::ST_ACC;
         end
         pcs_pkg::ST_ACC: begin
            sum_yy_in = sum_yy_ff + pcs_pkg::sum_p_type'(prod_ff);
            state_in  = last_ff ? pcs_pkg::ST_FIN : pcs_pkg::ST_IDLE;
         end
         pcs_pkg::ST_FIN: begin
            if (ovf_ff) begin
               res_corr_in   = '0;
               res_status_in = pcs_pkg::STATUS_OVF;
               state_in      = pcs_pkg::ST_OUT;
            end else begin
               phase_in = pcs_pkg::PH_N_XY;
               state_in = pcs_pkg::ST_LOAD;
            end
         end
         pcs_pkg::ST_LOAD: begin
            // set up one signed shift-add product; odd phases subtract
            case (phase_ff)
               pcs_pkg::PH_N_XY: begin
                  mcand_in = pcs_pkg::alu_word_type'(sum_xy_ff);
                  bsrc     = pcs_pkg::alu_word_type'(count_ff);
               end
               pcs_pkg::PH_X_Y: begin
                  mcand_in = pcs_pkg::alu_word_type'(sum_x_ff);
                  bsrc     = pcs_pkg::alu_word_type'(sum_y_ff);
               end
               pcs_pkg::PH_N_XX: begin
                  mcand_in = pcs_pkg::alu_word_type'(sum_xx_ff);
                  bsrc     = pcs_pkg::alu_word_type'(count_ff);
               end
               pcs_pkg::PH_X_X: begin
                  mcand_in = pcs_pkg::alu_word_type'(sum_x_ff);
                  bsrc     = pcs_pkg::alu_word_type'(sum_x_ff);
               end
               pcs_pkg::PH_N_YY: begin
                  mcand_in = pcs_pkg::alu_word_type'(sum_yy_ff);
                  bsrc     = pcs_pkg::alu_word_type'(count_ff);
               end
               pcs_pkg::PH_Y_Y: begin
                  mcand_in = pcs_pkg::alu_word_type'(sum_y_ff);
                  bsrc     = pcs_pkg::alu_word_type'(sum_y_ff);
               end
               pcs_pkg::PH_DEN: begin
                  mcand_in = pcs_pkg::alu_word_type'(root_x_ff);
                  bsrc     = pcs_pkg::alu_word_type'(root_ff);
               end
               default: begin
                  mcand_in = '0;
                  bsrc     = '0;
               end
            endcase
            alu_b     = bsrc;
            alu_sub   = bsrc[pcs_pkg::ALU_W-1];
            mplier_in = alu_sum[pcs_pkg::MPL_W-1:0];
            sub_in    = bsrc[pcs_pkg::ALU_W-1] ^
                        (phase_ff == pcs_pkg::PH_X_Y || phase_ff == pcs_pkg::PH_X_X ||
                         phase_ff == pcs_pkg::PH_Y_Y);
            if (phase_ff == pcs_pkg::PH_N_XY || phase_ff == pcs_pkg::PH_N_XX ||
                phase_ff == pcs_pkg::PH_N_YY || phase_ff == pcs_pkg::PH_DEN) begin
               acc_in = '0;
            end
            state_in = pcs_pkg::ST_MUL;
         end
         pcs_pkg::ST_MUL: begin
            alu_a   = acc_ff;
            alu_b   = mcand_ff;
            alu_sub = sub_ff;
            if (mplier_ff == '0) begin
               state_in = pcs_pkg::ST_LOAD;
               case (phase_ff)
                  pcs_pkg::PH_N_XY: phase_in = pcs_pkg::PH_X_Y;
                  pcs_pkg::PH_X_Y: begin
                     num_in   = acc_ff;
                     phase_in = pcs_pkg::PH_N_XX;
                  end
                  pcs_pkg::PH_N_XX: phase_in = pcs_pkg::PH_X_X;
                  pcs_pkg::PH_X_X: begin
                     dx_in    = acc_ff;
                     phase_in = pcs_pkg::PH_N_YY;
                  end
                  pcs_pkg::PH_N_YY: phase_in = pcs_pkg::PH_Y_Y;
                  pcs_pkg::PH_Y_Y: begin
                     dy_in    = acc_ff;
                     state_in = pcs_pkg::ST_CHECK;
                  end
                  pcs_pkg::PH_DEN: begin
                     den_in   = acc_ff;
                     state_in = pcs_pkg::ST_DIV_LD;
                  end
                  default: state_in = pcs_pkg::ST_IDLE;
               endcase
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = alu_sum;
               end
               mcand_in  = {mcand_ff[pcs_pkg::ALU_W-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[pcs_pkg::MPL_W-1:1]};
            end
         end
         pcs_pkg::ST_CHECK: begin
            if (dx_bad || dy_bad) begin
               res_corr_in   = '0;
               res_status_in = pcs_pkg::STATUS_FLAT;
               state_in      = pcs_pkg::ST_OUT;
            end else begin
               src_in    = dx_ff << pcs_pkg::SQRT_ALIGN;
               rem_in    = '0;
               root_in   = '0;
               step_in   = '0;
               sq_sel_in = 1'b0;
               state_in  = pcs_pkg::ST_SQRT;
            end
         end
         pcs_pkg::ST_SQRT: begin
            // one result bit per cycle, two radicand bits consumed
            rem_shift = {rem_ff[pcs_pkg::ALU_W-3:0], src_ff[pcs_pkg::ALU_W-1 -: 2]};
            alu_a     = rem_shift;
            alu_b     = pcs_pkg::alu_word_type'({root_ff, 2'b01});
            alu_sub   = 1'b1;
            if (!alu_sum[pcs_pkg::ALU_W-1]) begin
               rem_in  = alu_sum;
               root_in = {root_ff[pcs_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[pcs_pkg::ROOT_W-2:0], 1'b0};
            end
            src_in  = {src_ff[pcs_pkg::ALU_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == pcs_pkg::step_type'(pcs_pkg::SQRT_STEPS - 1)) begin
               if (!sq_sel_ff) begin
                  root_x_in = root_in;
                  sq_sel_in = 1'b1;
                  src_in    = dy_ff << pcs_pkg::SQRT_ALIGN;
                  rem_in    = '0;
                  root_in   = '0;
                  step_in   = '0;
               end else begin
                  phase_in = pcs_pkg::PH_DEN;
                  state_in = pcs_pkg::ST_LOAD;
               end
            end
         end
         pcs_pkg::ST_DIV_LD: begin
            alu_b    = num_ff;
            alu_sub  = num_ff[pcs_pkg::ALU_W-1];
            neg_in   = num_ff[pcs_pkg::ALU_W-1];
            src_in   = alu_sum << pcs_pkg::DIV_ALIGN;
            rem_in   = '0;
            q_in     = '0;
            sat_in   = 1'b0;
            step_in  = '0;
            state_in = pcs_pkg::ST_DIV;
         end
         pcs_pkg::ST_DIV: begin
            rem_shift = {rem_ff[pcs_pkg::ALU_W-2:0], src_ff[pcs_pkg::ALU_W-1]};
            alu_a     = rem_shift;
            alu_b     = den_ff;
            alu_sub   = 1'b1;
            rem_in    = alu_sum[pcs_pkg::ALU_W-1] ? rem_shift : alu_sum;
            // quotient bits past the Q1.15 range only mark saturation
            sat_in    = sat_ff || q_ff[pcs_pkg::CORR_W-1];
            q_in      = {q_ff[pcs_pkg::CORR_W-2:0], !alu_sum[pcs_pkg::ALU_W-1]};
            src_in    = {src_ff[pcs_pkg::ALU_W-2:0], 1'b0};
            step_in   = step_ff + 1'b1;
            if (step_ff == pcs_pkg::step_type'(pcs_pkg::DIV_STEPS - 1)) begin
               state_in = pcs_pkg::ST_RES;
            end
         end
         pcs_pkg::ST_RES: begin
            res_corr_in   = neg_ff ? (~mag + 1'b1) : mag;
            res_status_in = pcs_pkg::STATUS_OK;
            state_in      = pcs_pkg::ST_OUT;
         end
         pcs_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_corr_in   = res_corr_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               count_in      = '0;
               ovf_in        = 1'b0;
               sum_x_in      = '0;
               sum_y_in      = '0;
               sum_xy_in     = '0;
               sum_xx_in     = '0;
               sum_yy_in     = '0;
               state_in      = pcs_pkg::ST_IDLE;
            end
         end
         default: state_in = pcs_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/pcs_checker.sv =====
// Port-level checks for pearson_correlation_stream, bound to the top level.
// Depends on pcs_pkg.
`default_nettype none
module pcs_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire signed [pcs_pkg::CORR_W-1:0]    rsp_correlation,
   input wire [pcs_pkg::STATUS_W-1:0]         rsp_status
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correlation) &&
      $stable(rsp_status))
      else $error("response changed while stalled");

   // error results carry a zero coefficient
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pcs_pkg::STATUS_OK |-> rsp_correlation == '0)
      else $error("nonzero coefficient with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == pcs_pkg::STATUS_OK ||
                    rsp_status == pcs_pkg::STATUS_FLAT ||
                    rsp_status == pcs_pkg::STATUS_OVF)
      else $error("undefined status");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_correlation != {1'b1, {(pcs_pkg::CORR_W-1){1'b0}}})
      else $error("coefficient below clamp");

   // handshake signals are always known, response fields whenever rsp_valid is high
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}) &&
      (!rsp_valid || !$isunknown({rsp_correlation, rsp_status})))
      else $error("unknown value on response or ready");

endmodule

bind pearson_correlation_stream pcs_checker u_pcs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_correlation (rsp_correlation),
   .rsp_status      (rsp_status)
);
`default_nettype wire

// ===== tb/sv/tb_pearson_correlation_stream.sv =====
// Testbench for pearson_correlation_stream: random and directed pair sets,
// checked against a correlation scoreboard class. Depends on pcs_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

class corr_scoreboard;
   typedef struct {
      logic signed [pcs_pkg::CORR_W-1:0] corr;
      pcs_pkg::status_type               status;
      pcs_pkg::cnt_type                  count;
   } corr_result_type;

   corr_result_type pending[$];
   int             errors;
   longint         n_pairs;
   longint signed  sx, sy, sxy, sxx, syy;
   bit             ovf;

   function new();
      errors = 0;
      clear();
   endfunction

   function void clear();
      n_pairs = 0;
      sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
      ovf = 0;
   endfunction

   function logic [127:0] floor_root(logic [127:0] v);
      logic [127:0] r, c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // Fold one accepted request into the sums; predict a result on the last pair.
   function void note(logic signed [23:0] x, logic signed [23:0] y, logic last);
      longint signed xv, yv;
      logic signed [127:0] wn, wsx, wsy, num, dx, dy, mag;
      logic [127:0] den, q;
      corr_result_type e;
      xv = x;
      yv = y;
      if (n_pairs >= pcs_pkg::MAX_SAMPLES) begin
         ovf = 1;
      end else begin
         n_pairs++;
         sx += xv; sy += yv;
         sxy += xv * yv; sxx += xv * xv; syy += yv * yv;
      end
      if (!last) return;
      e.corr = 0;
      e.status = pcs_pkg::STATUS_OK;
      e.count = n_pairs[16:0];
      if (ovf) begin
         e.status = pcs_pkg::STATUS_OVF;
      end else begin
         wn = n_pairs; wsx = sx; wsy = sy;
         num = wn * $signed(128'(sxy)) - wsx * wsy;
         dx = wn * $signed(128'(sxx)) - wsx * wsx;
         dy = wn * $signed(128'(syy)) - wsy * wsy;
         if (dx <= 0 || dy <= 0) begin
            e.status = pcs_pkg::STATUS_FLAT;
         end else begin
            den = floor_root(dx) * floor_root(dy);
            mag = (num < 0) ? -num : num;
            q = (128'(mag) << pcs_pkg::Q_FRAC) / den;
            if (q > pcs_pkg::CORR_MAX) q = pcs_pkg::CORR_MAX;
            e.corr = (num < 0) ? -q[15:0] : q[15:0];
         end
      end
      pending = {pending, e};
      clear();
   endfunction

   function void check(logic signed [15:0] corr, pcs_pkg::status_type st,
                       pcs_pkg::cnt_type cnt);
      corr_result_type e;
      if (pending.size() == 0) begin
         $error("unexpected result corr=%0d status=%0d count=%0d", corr, st, cnt);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (corr !== e.corr) begin
         $error("correlation: expected %0d, got %0d", e.corr, corr);
         errors++;
      end
      if (st !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, st);
         errors++;
      end
      if (cnt !== e.count) begin
         $error("pair_count: expected %0d, got %0d", e.count, cnt);
         errors++;
      end
   endfunction
endclass

module tb_pearson_correlation_stream;
   localparam int WATCHDOG = 20000;

   logic clock, reset;
   logic req_valid, req_ready, req_last_pair;
   logic signed [23:0] req_x_sample, req_y_sample;
   logic rsp_valid, rsp_ready;
   logic signed [15:0] rsp_correlation;
   logic [1:0] rsp_status;
   logic [16:0] rsp_pair_count;

   corr_scoreboard sb;
   int send_idle_pct, recv_stall_pct;
   int quiet_cycles;

   pearson_correlation_stream u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_sample(req_x_sample), .req_y_sample(req_y_sample),
      .req_last_pair(req_last_pair),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_correlation(rsp_correlation), .rsp_status(rsp_status),
      .rsp_pair_count(rsp_pair_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // Monitor both channels and the watchdog on the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note(req_x_sample, req_y_sample, req_last_pair);
         if (rsp_valid && rsp_ready) sb.check(rsp_correlation, rsp_status, rsp_pair_count);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("pearson_correlation_stream test failed");
            $finish;
         end
      end else begin
         quiet_cycles = 0;
      end
   end

   // Present one request and hold it until accepted.
   task automatic send_pair(logic signed [23:0] x, logic signed [23:0] y, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_x_sample = x;
      req_y_sample = y;
      req_last_pair = last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic logic signed [23:0] rand_sample(int kind);
      case (kind)
         0: return 24'($urandom);
         1: return $signed(24'($urandom_range(64))) - 24'sd32;
         2: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
         default: return $signed(24'($urandom_range(2000))) - 24'sd1000;
      endcase
   endfunction

   task automatic random_set(int len);
      int kind, rel;
      logic signed [23:0] x, y, cx;
      kind = $urandom_range(3);
      rel = $urandom_range(4);
      cx = rand_sample(kind);
      for (int i = 0; i < len; i++) begin
         x = rand_sample(kind);
         case (rel)
            0: y = rand_sample(kind);
            1: y = x + rand_sample(1);
            2: y = -x + rand_sample(1);
            3: begin
               y = rand_sample(kind);
               x = cx;      // flat series
            end
            default: y = (x >>> 2) + rand_sample(3);
         endcase
         send_pair(x, y, i == len - 1);
      end
   endtask

   initial begin
      int sent, len;
      sb = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      req_valid = 0; req_x_sample = 0; req_y_sample = 0; req_last_pair = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: single pair, perfect and inverse trends, extremes, flat.
      send_pair(24'sd5, 24'sd7, 1);
      send_pair(24'sd1, 24'sd2, 0);
      send_pair(24'sd3, 24'sd6, 1);
      send_pair(24'sd1, -24'sd2, 0);
      send_pair(24'sd3, -24'sd6, 1);
      send_pair(24'sh800000, 24'sh800000, 0);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF, 1);
      send_pair(24'sh800000, 24'sh7FFFFF, 0);
      send_pair(24'sh7FFFFF, 24'sh800000, 1);
      send_pair(24'sd4, 24'sd1, 0);
      send_pair(24'sd4, 24'sd9, 0);
      send_pair(24'sd4, -24'sd3, 1);
      send_pair(24'sd0, 24'sd0, 0);
      send_pair(24'sd0, 24'sd0, 1);
      send_pair(24'sh800000, 24'sd0, 0);
      send_pair(24'sh7FFFFF, 24'sd1, 0);
      send_pair(-24'sd1, 24'sh7FFFFF, 0);
      send_pair(24'sd12, 24'sh800000, 1);

      sent = 0;
      while (sent < 700) begin
         case ((sent / 60) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
         random_set(len);
         sent += len;
      end
      idle_sender();

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("pearson_correlation_stream test passed");
      else
         $display("pearson_correlation_stream test failed");
      $finish;
   end
endmodule

`default_nettype wire
